### rtl/rep_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the relocation entry patcher.
package rep_pkg;

	localparam int unsigned KindW   = 8;
	localparam int unsigned OffW    = 32;
	localparam int unsigned AddrW   = 64;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [KindW-1:0] KIND_ABS64 = 8'd0;
	localparam logic [KindW-1:0] KIND_ABS32 = 8'd1;
	localparam logic [KindW-1:0] KIND_PC32  = 8'd2;
	localparam logic [KindW-1:0] KIND_PLT32 = 8'd3;

	localparam logic [3:0] WIDTH_WIDE   = 4'd8;
	localparam logic [3:0] WIDTH_NARROW = 4'd4;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_KIND   = 2'd1,
		STATUS_BAD_PLACE  = 2'd2,
		STATUS_BAD_TARGET = 2'd3
	} rep_status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_LOAD_BASE    = 2'd0,
		REG_LOADED_BYTES = 2'd1,
		REG_IMAGE_SPAN   = 2'd2
	} rep_reg_idx_t;

	typedef struct packed {
		logic [AddrW-1:0] load_base;
		logic [OffW-1:0]  loaded_bytes;
		logic [OffW-1:0]  image_span;
	} rep_cfg_t;

endpackage

### rtl/rep_if.sv
`timescale 1ns / 1ps
// Channel interfaces: relocation entries, results and configuration writes.
interface rep_entry_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reloc_kind;
	logic [31:0] patch_offset;
	logic [31:0] symbol_offset;
	logic signed [31:0] addend;

	modport source (output valid, reloc_kind, patch_offset, symbol_offset, addend,
		input ready);
	modport sink (input valid, reloc_kind, patch_offset, symbol_offset, addend,
		output ready);
endinterface

interface rep_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] write_address;
	logic        write_eight_bytes;
	logic [63:0] patch_value;

	modport source (output valid, status, write_address, write_eight_bytes, patch_value,
		input ready);
	modport sink (input valid, status, write_address, write_eight_bytes, patch_value,
		output ready);
endinterface

interface rep_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [63:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

### rtl/rep_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file for the relocation entry patcher.
module rep_cfg_regs
	import rep_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rep_cfg_if.sink   cfg,
	output rep_cfg_t  regs
);

	rep_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (rep_reg_idx_t'(cfg.reg_index))
				REG_LOAD_BASE:    regs_q.load_base    <= cfg.wdata;
				REG_LOADED_BYTES: regs_q.loaded_bytes <= cfg.wdata[OffW-1:0];
				REG_IMAGE_SPAN:   regs_q.image_span   <= cfg.wdata[OffW-1:0];
				default: ; // drop writes to unmapped indexes
			endcase
		end
	end

endmodule

### rtl/relocation_entry_patcher.sv
`timescale 1ns / 1ps
// Top level of the relocation entry patcher: three-stage check and patch pipeline.
//
// Usage:
//   entry  - one RELA entry per beat (kind, patch offset, symbol offset, addend).
//   result - one beat per entry, in entry order: status, absolute write address,
//            eight-byte flag and value to store. Rejected entries carry zero
//            address, flag and value.
//   cfg    - register writes (load base, loaded bytes, image bytes). Always ready;
//            write only while no entry is in flight.
// Pipeline: an entry beat passes stage 1 (sums), stage 2 (range compares and
//   64-bit base adds) and stage 3 (value select into the output register),
//   whose beat shows on the result channel.
// Throughput: one entry per cycle while the receiver keeps result.ready high;
//   each stage holds adds or compares no wider than 64 bits.
// Reset: arst_n clears all stage valid bits and the configuration registers
//   to zero; the pipeline comes up empty and ready.
// Stall: when the receiver holds ready low, the output stage holds its beat and
//   upstream stages fill in turn; entry.ready drops only once every stage holds
//   a beat, so nothing is lost or repeated.
module relocation_entry_patcher
	import rep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rep_entry_if.sink   entry,
	rep_result_if.source result,
	rep_cfg_if.sink     cfg
);

	rep_cfg_t cfg_regs;

	rep_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// Stage enables: a stage advances when it is empty or the next one advances.
	logic adv_s1, adv_s2, adv_s3;

	logic v_s1, v_s2, v_s3;

	// Stage 1 registers
	logic            kind_ok_s1;
	logic [1:0]      kind_s1;
	logic [OffW-1:0] poff_s1;
	logic [OffW:0]   place_end_s1;
	logic [OffW:0]   tgt_end_s1;
	logic [AddrW-1:0] off_sum_s1;
	logic [OffW-1:0] pcrel_s1;

	// Stage 2 registers
	rep_status_t      status_s2;
	logic [1:0]       kind_s2;
	logic [AddrW-1:0] place_s2;
	logic [AddrW-1:0] sum_s2;
	logic [OffW-1:0]  pcrel_s2;

	// Stage 3 (output) registers
	rep_status_t      status_s3;
	logic [AddrW-1:0] addr_s3;
	logic             wide_s3;
	logic [AddrW-1:0] value_s3;

	assign adv_s3      = !v_s3 || result.ready;
	assign adv_s2      = !v_s2 || adv_s3;
	assign adv_s1      = !v_s1 || adv_s2;
	assign entry.ready = adv_s1;

	// Stage 1 combinational: magnitude of addend, end-of-range sums, offset sums.
	logic            is_wide_c;
	logic [OffW-1:0] mag_c;
	logic [3:0]      width_c;

	always_comb begin
		is_wide_c = (entry.reloc_kind == KIND_ABS64);
		width_c   = is_wide_c ? WIDTH_WIDE : WIDTH_NARROW;
		// Most negative addend maps to 2^31, which fits the unsigned 32 bits.
		mag_c     = entry.addend[OffW-1] ? (~entry.addend + 32'd1) : entry.addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && entry.valid) begin
			kind_ok_s1   <= (entry.reloc_kind <= KIND_PLT32);
			kind_s1      <= entry.reloc_kind[1:0];
			poff_s1      <= entry.patch_offset;
			place_end_s1 <= {1'b0, entry.patch_offset} + {29'd0, width_c};
			tgt_end_s1   <= {1'b0, entry.symbol_offset} + {1'b0, mag_c};
			off_sum_s1   <= {32'd0, entry.symbol_offset}
				+ {{32{entry.addend[OffW-1]}}, entry.addend};
			// Load base cancels in target - place, so the low 32 bits need offsets only.
			pcrel_s1     <= entry.symbol_offset + entry.addend - entry.patch_offset
				- {28'd0, WIDTH_NARROW};
		end
	end

	// Stage 2: range checks in priority order, then base-relative addresses.
	rep_status_t status_c;

	always_comb begin
		if (!kind_ok_s1) begin
			status_c = STATUS_BAD_KIND;
		end else if (place_end_s1 > {1'b0, cfg_regs.loaded_bytes}) begin
			status_c = STATUS_BAD_PLACE;
		end else if (tgt_end_s1 > {1'b0, cfg_regs.image_span}) begin
			status_c = STATUS_BAD_TARGET;
		end else begin
			status_c = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			status_s2 <= status_c;
			kind_s2   <= kind_s1;
			place_s2  <= cfg_regs.load_base + {32'd0, poff_s1};
			sum_s2    <= cfg_regs.load_base + off_sum_s1;
			pcrel_s2  <= pcrel_s1;
		end
	end

	// Stage 3: pick the value by kind, zero everything on a rejected entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			status_s3 <= status_s2;
			if (status_s2 != STATUS_OK) begin
				addr_s3  <= '0;
				wide_s3  <= 1'b0;
				value_s3 <= '0;
			end else begin
				addr_s3 <= place_s2;
				case ({6'd0, kind_s2})
					KIND_ABS64: begin
						wide_s3  <= 1'b1;
						value_s3 <= sum_s2;
					end
					KIND_ABS32: begin
						wide_s3  <= 1'b0;
						value_s3 <= {32'd0, sum_s2[OffW-1:0]};
					end
					default: begin
						// pc32 and plt32 share the place-relative form
						wide_s3  <= 1'b0;
						value_s3 <= {32'd0, pcrel_s2};
					end
				endcase
			end
		end
	end

	assign result.valid             = v_s3;
	assign result.status            = status_s3;
	assign result.write_address     = addr_s3;
	assign result.write_eight_bytes = wide_s3;
	assign result.patch_value       = value_s3;

endmodule

### rtl/rep_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the relocation entry patcher, with its bind.
module rep_checker
	import rep_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  res_status,
	input logic [63:0] res_write_address,
	input logic        res_write_eight_bytes,
	input logic [63:0] res_patch_value
);

	// A stalled result beat holds its status, address and value.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_patch_value)
			&& $stable(res_write_address) && $stable(res_status))
		else $error("result beat changed while stalled");

	// A rejected entry carries zero address, flag and value.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != STATUS_OK |->
			res_write_address == '0 && !res_write_eight_bytes && res_patch_value == '0)
		else $error("rejected entry has nonzero payload");

	// Eight-byte patches come only from accepted entries.
	a_wide_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_write_eight_bytes |-> res_status == STATUS_OK)
		else $error("eight-byte patch on a rejected entry");

	// Four-byte patches carry a zero-extended value.
	a_narrow_ext: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_write_eight_bytes |-> res_patch_value[63:32] == 32'd0)
		else $error("four-byte patch value not zero-extended");

endmodule

bind relocation_entry_patcher rep_checker u_rep_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.res_valid             (result.valid),
	.res_ready             (result.ready),
	.res_status            (result.status),
	.res_write_address     (result.write_address),
	.res_write_eight_bytes (result.write_eight_bytes),
	.res_patch_value       (result.patch_value)
);
